>>> src/dcad_pkg.sv
// shared types and constants for the duty-cycle accelerometer decoder
package dcad_pkg;

  localparam int DATA_W       = 16;
  localparam int PERIOD_SHIFT = 9;
  localparam int DIV_W        = DATA_W - PERIOD_SHIFT;
  localparam int STEP_W       = $clog2(DATA_W + 1);

  localparam logic [DATA_W-1:0] RATIO_SAT = {DATA_W{1'b1}};

  localparam logic CH_X = 1'b0;
  localparam logic CH_Y = 1'b1;

  typedef enum logic [1:0] {
    PH_RISE_X,
    PH_FALL_X,
    PH_RISE_Y,
    PH_FALL_Y
  } dcad_phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_X,
    S_DIV_Y,
    S_SUM,
    S_DONE
  } dcad_state_t;

endpackage

>>> src/dcad_ram.sv
// generic single-write, single-read ram with registered read data
module dcad_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/dcad_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
module dcad_divider
  import dcad_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  logic              busy;
  logic [STEP_W-1:0] count;
  logic [DIV_W-1:0]  dvsr;
  logic [DIV_W-1:0]  rem;
  logic [DATA_W-1:0] quo;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;

  // dividend bits shift out of the top of quo while quotient bits shift in
  always_comb begin
    trial = {rem, quo[DATA_W-1]};
    ge    = (trial >= {1'b0, dvsr});
    diff  = trial - {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= STEP_W'(DATA_W);
      end else if (busy) begin
        count <= count - STEP_W'(1);
        if (count == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvsr <= divisor;
      rem  <= '0;
      quo  <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo <= {quo[DATA_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

>>> src/duty_cycle_accel_decoder_top.sv
// top level: edge sequencer, shared divider, moving-sum ring and output register
//
//   port group    | direction | handshake            | payload
//   --------------+-----------+----------------------+-------------------------------
//   edge request  | in        | in_valid / in_ready  | edge_channel, edge_rising, edge_time
//   ratio result  | out       | out_valid / out_ready| ratio_x, ratio_y, sum_x, sum_y, divide_fault
//
// an edge that does not end a cycle leaves the sequencer idle; the falling y edge is worked
// by the shared divider, which forms two 16-bit quotients one bit per cycle
// with a zero divisor the divider is skipped and the edge goes straight to the sum step
// reset clears the sequencer, running sums, ring head and wrap flag; no clearing pass is run
// in_ready is low while a request is being worked; a finished result waits in the output
// register, and a later one holds in the done state until out_ready frees the register
module duty_cycle_accel_decoder_top
  import dcad_pkg::*;
#(
  parameter int AVG_DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              edge_channel,
  input  logic              edge_rising,
  input  logic [DATA_W-1:0] edge_time,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] ratio_x,
  output logic [DATA_W-1:0] ratio_y,
  output logic [DATA_W-1:0] sum_x,
  output logic [DATA_W-1:0] sum_y,
  output logic              divide_fault
);

  localparam int HEAD_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(AVG_DEPTH - 1);

  dcad_state_t state, state_next;
  dcad_phase_t phase;

  logic [DATA_W-1:0] rise_x_time;
  logic [DATA_W-1:0] fall_x_time;
  logic [DATA_W-1:0] rise_y_time;
  logic [DATA_W-1:0] high_x_double;
  logic [DATA_W-1:0] high_y_double;
  logic [DATA_W-1:0] period_accum;
  logic [DATA_W-1:0] period_final;
  logic [DIV_W-1:0]  divisor;
  logic [DIV_W-1:0]  divisor_next;
  logic [DATA_W-1:0] rx;
  logic [DATA_W-1:0] ry;
  logic              fault;
  logic [DATA_W-1:0] running_x;
  logic [DATA_W-1:0] running_y;
  logic [HEAD_W-1:0] ring_head;
  logic              ring_wrapped;

  logic              in_fire;
  logic              last_edge;
  logic              div_start;
  logic [DATA_W-1:0] div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic              div_done;
  logic [DATA_W-1:0] div_quotient;
  logic              ring_we;
  logic [2*DATA_W-1:0] ring_rdata;
  logic [DATA_W-1:0] old_x;
  logic [DATA_W-1:0] old_y;
  logic              out_load;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign last_edge = (phase == PH_FALL_Y) && (edge_channel == CH_Y) && !edge_rising;

  assign period_final = period_accum + (edge_time - fall_x_time);
  assign divisor_next = period_final[DATA_W-1:PERIOD_SHIFT];

  // first start takes the divisor straight from the edge, the second from the register
  assign div_divisor = (state == S_IDLE) ? divisor_next : divisor;

  // ring entries not yet written since reset count as zero
  assign old_x = ring_wrapped ? ring_rdata[DATA_W-1:0] : '0;
  assign old_y = ring_wrapped ? ring_rdata[2*DATA_W-1:DATA_W] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = high_x_double;
    ring_we      = 1'b0;
    out_load     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_fire && last_edge) begin
          if (divisor_next == '0) begin
            state_next = S_SUM;
          end else begin
            div_start  = 1'b1;
            state_next = S_DIV_X;
          end
        end
      end
      S_DIV_X: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = high_y_double;
          state_next   = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        if (div_done) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        ring_we    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // edge tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_RISE_X;
    end else if (in_fire) begin
      unique case (phase)
        PH_RISE_X: if (edge_channel == CH_X && edge_rising) phase <= PH_FALL_X;
        PH_FALL_X: if (edge_channel == CH_X && !edge_rising) phase <= PH_RISE_Y;
        PH_RISE_Y: if (edge_channel == CH_Y && edge_rising) phase <= PH_FALL_Y;
        PH_FALL_Y: if (last_edge) phase <= PH_RISE_X;
        default:   phase <= PH_RISE_X;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      unique case (phase)
        PH_RISE_X: begin
          if (edge_channel == CH_X && edge_rising) rise_x_time <= edge_time;
        end
        PH_FALL_X: begin
          if (edge_channel == CH_X && !edge_rising) begin
            fall_x_time   <= edge_time;
            high_x_double <= {edge_time[DATA_W-2:0] - rise_x_time[DATA_W-2:0], 1'b0};
          end
        end
        PH_RISE_Y: begin
          if (edge_channel == CH_Y && edge_rising) begin
            rise_y_time  <= edge_time;
            period_accum <= edge_time - rise_x_time;
          end
        end
        PH_FALL_Y: begin
          if (last_edge) begin
            high_y_double <= {edge_time[DATA_W-2:0] - rise_y_time[DATA_W-2:0], 1'b0};
            period_accum  <= period_final;
            divisor       <= divisor_next;
          end
        end
        default: ;
      endcase
    end
  end

  // quotients, or saturation on a zero divisor
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_fire && last_edge) begin
      rx    <= RATIO_SAT;
      ry    <= RATIO_SAT;
      fault <= (divisor_next == '0);
    end else if (state == S_DIV_X && div_done) begin
      rx <= div_quotient;
    end else if (state == S_DIV_Y && div_done) begin
      ry <= div_quotient;
    end
  end

  // moving sums over the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      running_x    <= '0;
      running_y    <= '0;
      ring_head    <= '0;
      ring_wrapped <= 1'b0;
    end else if (ring_we) begin
      running_x <= running_x - old_x + rx;
      running_y <= running_y - old_y + ry;
      if (ring_head == HEAD_LAST) begin
        ring_head    <= '0;
        ring_wrapped <= 1'b1;
      end else begin
        ring_head <= ring_head + HEAD_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ratio_x      <= rx;
      ratio_y      <= ry;
      sum_x        <= running_x;
      sum_y        <= running_y;
      divide_fault <= fault;
    end
  end

  dcad_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  dcad_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (AVG_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_head),
    .wdata ({ry, rx}),
    .raddr (ring_head),
    .rdata (ring_rdata)
  );

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_X || state == S_DIV_Y))
    else $error("divider finished outside a divide state");

  a_fault_sat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_fault) |-> (ratio_x == RATIO_SAT && ratio_y == RATIO_SAT))
    else $error("fault result without saturated ratios");

  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_load) |=> !out_valid)
    else $error("result still valid after it was taken");

  a_busy_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_X || state == S_DIV_Y) |-> !in_ready)
    else $error("input ready while dividing");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    ring_we |=> (ring_head == '0 || ring_head == $past(ring_head) + HEAD_W'(1)))
    else $error("ring head skipped an entry");

endmodule
